FILE: src/tpcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tpcr_pkg;

    // Storage sizes
    localparam int VIDEO_BYTES  = 65536;
    localparam int COLOUR_BYTES = 128;
    localparam int VA_W         = $clog2(VIDEO_BYTES);
    // Colour memory is split into an even and an odd half of COLOUR_BYTES/2 bytes
    localparam int CA_W         = $clog2(COLOUR_BYTES / 2);

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH  = 4;

    // Input word kinds
    localparam logic [1:0] KIND_VRAM   = 2'd0;
    localparam logic [1:0] KIND_CRAM   = 2'd1;
    localparam logic [1:0] KIND_RENDER = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_PLANE_BASE    = 2'd0;
    localparam logic [1:0] REG_WIDTH_CODE    = 2'd1;
    localparam logic [1:0] REG_HEIGHT_CODE   = 2'd2;
    localparam logic [1:0] REG_PRIORITY_PASS = 2'd3;

    // log2 of the plane size in tiles, per width or height code
    localparam logic [2:0] PLANE_SHIFT [4] = '{3'd5, 3'd6, 3'd6, 3'd7};

    typedef enum logic [1:0] {
        OP_VRAM,
        OP_CRAM,
        OP_RENDER
    } t_op;

    // One queued job; for a render, addr already holds the map entry address
    typedef struct packed {
        t_op         op;
        logic [15:0] addr;
        logic [7:0]  wbyte;
        logic [6:0]  col;
        logic [6:0]  row;
    } t_job;

    typedef struct packed {
        logic [15:0] plane_base;
        logic [1:0]  width_code;
        logic [1:0]  height_code;
        logic        priority_pass;
    } t_cfg;

    // True when a tile coordinate lies inside a plane of 2**sh tiles
    function automatic logic cell_fits(input logic [6:0] coord, input logic [2:0] sh);
        return (coord >> sh) == 7'd0;
    endfunction

    // Byte address of a cell's map entry, wrapping at 16 bits
    function automatic logic [15:0] map_addr(input logic [15:0] base,
                                             input logic [2:0]  sh,
                                             input logic [6:0]  col,
                                             input logic [6:0]  row);
        logic [13:0] idx;
        idx = ({7'd0, row} << sh) + {7'd0, col};
        return base + {1'b0, idx, 1'b0};
    endfunction

endpackage

`default_nettype wire

FILE: src/tpcr_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input words: memory writes and render requests
interface tpcr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [15:0] mem_address;
    logic [7:0] write_byte;
    logic [6:0] cell_column;
    logic [6:0] cell_row;

    modport source (output valid, kind, mem_address, write_byte, cell_column, cell_row,
                    input ready);
    modport sink   (input valid, kind, mem_address, write_byte, cell_column, cell_row,
                    output ready);
endinterface

// Pixel result words
interface tpcr_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic [23:0] colour;
    logic        drawn;
    logic        last_pixel;

    modport source (output valid, pixel_x, pixel_y, colour, drawn, last_pixel,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, colour, drawn, last_pixel,
                    output ready);
endinterface

// Configuration register writes
interface tpcr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/tpcr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tpcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, and read port with registered data that holds while disabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/tpcr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tpcr_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    tpcr_in_if.sink             i_in,
    input  wire tpcr_pkg::t_cfg i_cfg,
    input  wire logic           i_pop,
    output logic                o_avail,
    output tpcr_pkg::t_job      o_job
);
    import tpcr_pkg::*;

    localparam int QP_W = $clog2(QUEUE_DEPTH);

    t_job              r_queue [QUEUE_DEPTH];
    logic [QP_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QP_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QP_W:0]     r_count,  n_count;

    logic              accept;
    logic              push;
    logic              render_fits;
    logic [2:0]        w_sh;
    logic [2:0]        h_sh;
    t_job              job;

    assign i_in.ready = (r_count != (QP_W + 1)'(QUEUE_DEPTH));
    assign accept     = i_in.valid && i_in.ready;

    // Classify the word: drop unused kinds and cells outside the plane
    assign w_sh        = PLANE_SHIFT[i_cfg.width_code];
    assign h_sh        = PLANE_SHIFT[i_cfg.height_code];
    assign render_fits = cell_fits(i_in.cell_column, w_sh) && cell_fits(i_in.cell_row, h_sh);

    always_comb begin
        job.wbyte = i_in.write_byte;
        job.col   = i_in.cell_column;
        job.row   = i_in.cell_row;
        job.addr  = i_in.mem_address;
        job.op    = OP_VRAM;
        push      = 1'b0;
        priority if (i_in.kind == KIND_VRAM) begin
            job.op = OP_VRAM;
            push   = accept;
        end else if (i_in.kind == KIND_CRAM) begin
            job.op = OP_CRAM;
            push   = accept;
        end else if (i_in.kind == KIND_RENDER) begin
            job.op   = OP_RENDER;
            job.addr = map_addr(i_cfg.plane_base, w_sh, i_in.cell_column, i_in.cell_row);
            push     = accept && render_fits;
        end else begin
            push = 1'b0;
        end
    end

    // Advance queue pointers and occupancy
    always_comb begin
        n_wr_ptr = push  ? r_wr_ptr + QP_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + QP_W'(1) : r_rd_ptr;
        n_count  = r_count + (QP_W + 1)'(push) - (QP_W + 1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= job;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_avail = (r_count != '0);
    assign o_job   = r_queue[r_rd_ptr];

endmodule

`default_nettype wire

FILE: src/tpcr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tpcr_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tpcr_pkg::t_cfg i_cfg,
    input  wire logic           i_avail,
    input  wire tpcr_pkg::t_job i_job,
    output logic                o_pop,
    tpcr_out_if.source          o_px
);
    import tpcr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP_HI,
        ST_MAP_LO,
        ST_MAP_WAIT,
        ST_PIX
    } t_state;

    t_state r_state, n_state;

    // Current cell
    logic [6:0]  r_col, n_col;
    logic [6:0]  r_row, n_row;
    logic [15:0] r_maddr, n_maddr;
    logic [7:0]  r_entry_hi, n_entry_hi;
    logic [10:0] r_tile, n_tile;
    logic [1:0]  r_pal, n_pal;
    logic        r_hflip, n_hflip;
    logic        r_vflip, n_vflip;
    logic        r_pri_ok, n_pri_ok;
    logic [5:0]  r_n, n_n;

    // Stage B: tile byte arriving
    logic        r_b_valid, n_b_valid;
    logic        r_b_lo, n_b_lo;
    logic [9:0]  r_b_x, n_b_x;
    logic [9:0]  r_b_y, n_b_y;
    logic        r_b_last, n_b_last;

    // Stage C: colour bytes arriving
    logic        r_c_valid, n_c_valid;
    logic        r_c_draw, n_c_draw;
    logic [9:0]  r_c_x, n_c_x;
    logic [9:0]  r_c_y, n_c_y;
    logic        r_c_last, n_c_last;

    // Output register
    logic        r_out_valid, n_out_valid;
    logic [9:0]  r_out_x, n_out_x;
    logic [9:0]  r_out_y, n_out_y;
    logic [23:0] r_out_colour, n_out_colour;
    logic        r_out_drawn, n_out_drawn;
    logic        r_out_last, n_out_last;

    logic            adv;
    logic [2:0]      ty;
    logic [2:0]      tx;
    logic [15:0]     tile_addr;
    logic [VA_W-1:0] v_raddr;
    logic [7:0]      v_rdata;
    logic [3:0]      pix;
    logic [CA_W-1:0] c_raddr;
    logic [7:0]      c0_rdata;
    logic [7:0]      c1_rdata;
    logic            v_we;
    logic            ce_we;
    logic            co_we;

    // The whole read pipeline moves only when the output register can take a word
    assign adv   = !r_out_valid || o_px.ready;
    // Hold the next word while a stalled pixel still owes its colour read
    assign o_pop = (r_state == ST_IDLE) && i_avail && (adv || !r_b_valid);

    // Memory writes are carried out as they leave the queue
    assign v_we  = o_pop && (i_job.op == OP_VRAM);
    assign ce_we = o_pop && (i_job.op == OP_CRAM) && !i_job.addr[0];
    assign co_we = o_pop && (i_job.op == OP_CRAM) &&  i_job.addr[0];

    // Tile byte address for the current pixel
    assign ty        = r_n[5:3] ^ {3{r_vflip}};
    assign tx        = r_n[2:0] ^ {3{r_hflip}};
    assign tile_addr = {r_tile, ty, tx[2:1]};

    always_comb begin
        unique case (r_state)
            ST_MAP_HI: v_raddr = r_maddr[VA_W-1:0];
            ST_MAP_LO: v_raddr = 16'(r_maddr + 16'd1) & 16'(VIDEO_BYTES - 1);
            ST_PIX:    v_raddr = tile_addr[VA_W-1:0];
            default:   v_raddr = r_maddr[VA_W-1:0];
        endcase
    end

    // Pick the nibble and look up its palette pair
    assign pix     = r_b_lo ? v_rdata[3:0] : v_rdata[7:4];
    assign c_raddr = CA_W'({r_pal, pix});

    tpcr_ram #(.WIDTH(8), .DEPTH(VIDEO_BYTES)) u_vram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (i_job.addr[VA_W-1:0]),
        .i_wdata (i_job.wbyte),
        .i_re    (adv),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    tpcr_ram #(.WIDTH(8), .DEPTH(COLOUR_BYTES / 2)) u_cram_even (
        .i_clk   (i_clk),
        .i_we    (ce_we),
        .i_waddr (i_job.addr[CA_W:1]),
        .i_wdata (i_job.wbyte),
        .i_re    (adv),
        .i_raddr (c_raddr),
        .o_rdata (c0_rdata)
    );

    tpcr_ram #(.WIDTH(8), .DEPTH(COLOUR_BYTES / 2)) u_cram_odd (
        .i_clk   (i_clk),
        .i_we    (co_we),
        .i_waddr (i_job.addr[CA_W:1]),
        .i_wdata (i_job.wbyte),
        .i_re    (adv),
        .i_raddr (c_raddr),
        .o_rdata (c1_rdata)
    );

    // Sequencer: map entry fetch, then one tile read per pixel
    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_maddr    = r_maddr;
        n_entry_hi = r_entry_hi;
        n_tile     = r_tile;
        n_pal      = r_pal;
        n_hflip    = r_hflip;
        n_vflip    = r_vflip;
        n_pri_ok   = r_pri_ok;
        n_n        = r_n;
        n_b_valid  = r_b_valid;
        n_b_lo     = r_b_lo;
        n_b_x      = r_b_x;
        n_b_y      = r_b_y;
        n_b_last   = r_b_last;

        unique case (r_state)
            ST_IDLE: begin
                if (o_pop && (i_job.op == OP_RENDER)) begin
                    n_col   = i_job.col;
                    n_row   = i_job.row;
                    n_maddr = i_job.addr;
                    n_state = ST_MAP_HI;
                end
            end
            ST_MAP_HI: begin
                if (adv) begin
                    n_state = ST_MAP_LO;
                end
            end
            ST_MAP_LO: begin
                if (adv) begin
                    n_entry_hi = v_rdata;
                    n_state    = ST_MAP_WAIT;
                end
            end
            ST_MAP_WAIT: begin
                if (adv) begin
                    n_tile   = r_entry_hi[2:0] == 3'd0 ? {3'd0, v_rdata} : {r_entry_hi[2:0], v_rdata};
                    n_hflip  = r_entry_hi[3];
                    n_vflip  = r_entry_hi[4];
                    n_pal    = r_entry_hi[6:5];
                    n_pri_ok = (r_entry_hi[7] == i_cfg.priority_pass);
                    n_n      = '0;
                    n_state  = ST_PIX;
                end
            end
            ST_PIX: begin
                if (adv) begin
                    n_b_lo   = tx[0];
                    n_b_x    = {r_col, r_n[2:0]};
                    n_b_y    = {r_row, r_n[5:3]};
                    n_b_last = &r_n;
                    n_n      = r_n + 6'd1;
                    if (&r_n) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (adv) begin
            n_b_valid = (r_state == ST_PIX);
        end
    end

    // Stages C and output
    always_comb begin
        n_c_valid    = r_c_valid;
        n_c_draw     = r_c_draw;
        n_c_x        = r_c_x;
        n_c_y        = r_c_y;
        n_c_last     = r_c_last;
        n_out_valid  = r_out_valid;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_colour = r_out_colour;
        n_out_drawn  = r_out_drawn;
        n_out_last   = r_out_last;
        if (adv) begin
            n_c_valid    = r_b_valid;
            n_c_draw     = (pix != 4'd0) && r_pri_ok;
            n_c_x        = r_b_x;
            n_c_y        = r_b_y;
            n_c_last     = r_b_last;
            n_out_valid  = r_c_valid;
            n_out_x      = r_c_x;
            n_out_y      = r_c_y;
            n_out_drawn  = r_c_draw;
            n_out_last   = r_c_last;
            n_out_colour = r_c_draw ? {c0_rdata[3:1], 5'd0, c0_rdata[7:5], 5'd0,
                                       c1_rdata[3:1], 5'd0} : 24'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col        <= n_col;
        r_row        <= n_row;
        r_maddr      <= n_maddr;
        r_entry_hi   <= n_entry_hi;
        r_tile       <= n_tile;
        r_pal        <= n_pal;
        r_hflip      <= n_hflip;
        r_vflip      <= n_vflip;
        r_pri_ok     <= n_pri_ok;
        r_n          <= n_n;
        r_b_lo       <= n_b_lo;
        r_b_x        <= n_b_x;
        r_b_y        <= n_b_y;
        r_b_last     <= n_b_last;
        r_c_draw     <= n_c_draw;
        r_c_x        <= n_c_x;
        r_c_y        <= n_c_y;
        r_c_last     <= n_c_last;
        r_out_x      <= n_out_x;
        r_out_y      <= n_out_y;
        r_out_colour <= n_out_colour;
        r_out_drawn  <= n_out_drawn;
        r_out_last   <= n_out_last;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_b_valid   <= n_b_valid;
            r_c_valid   <= n_c_valid;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_px.valid      = r_out_valid;
    assign o_px.pixel_x    = r_out_x;
    assign o_px.pixel_y    = r_out_y;
    assign o_px.colour     = r_out_colour;
    assign o_px.drawn      = r_out_drawn;
    assign o_px.last_pixel = r_out_last;

endmodule

`default_nettype wire

FILE: src/tile_plane_cell_renderer.sv
`timescale 1ns / 1ps
`default_nettype none

// Renders one 8x8 cell of a 4-bit-per-pixel tile-map plane from an internal 64 KiB video
// memory and 128-byte colour memory, both loaded through the input channel. A memory
// write word is done as it leaves the queue. A render word of a cell inside the plane
// fetches and decodes its two-byte map entry, then gives one pixel word per cycle unless
// the output stalls, the rate being set by the single read port of the video memory,
// which delivers one tile byte per pixel. Render words for cells outside the plane and
// words of the unused kind are taken and dropped. A four-word queue sits between the
// input and the renderer, so the input can keep taking words while pixels wait at the
// output. Memory bytes that were never written read back as arbitrary values.
// Configuration is taken at any time but must only change while the block is idle.
module tile_plane_cell_renderer (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tpcr_in_if.sink    i_in,
    tpcr_cfg_if.sink   i_cfg,
    tpcr_out_if.source o_px
);
    import tpcr_pkg::*;

    t_cfg r_cfg;
    logic q_avail;
    logic q_pop;
    t_job q_job;

    // Register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_PLANE_BASE:    r_cfg.plane_base    <= i_cfg.data;
                REG_WIDTH_CODE:    r_cfg.width_code    <= i_cfg.data[1:0];
                REG_HEIGHT_CODE:   r_cfg.height_code   <= i_cfg.data[1:0];
                REG_PRIORITY_PASS: r_cfg.priority_pass <= i_cfg.data[0];
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    tpcr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_pop   (q_pop),
        .o_avail (q_avail),
        .o_job   (q_job)
    );

    tpcr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_avail (q_avail),
        .i_job   (q_job),
        .o_pop   (q_pop),
        .o_px    (o_px)
    );

    // The back end never takes a word from an empty queue
    a_pop_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_avail)
        else $error("queue popped while empty");

    // An undrawn pixel carries no colour
    a_undrawn_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_px.valid && !o_px.drawn) |-> (o_px.colour == 24'd0))
        else $error("undrawn pixel with nonzero colour");

    // The last pixel of a cell is its bottom-right corner
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_px.valid && o_px.last_pixel) |->
            (o_px.pixel_x[2:0] == 3'd7 && o_px.pixel_y[2:0] == 3'd7))
        else $error("last pixel flag away from cell corner");

endmodule

`default_nettype wire
